FILE: sv/ppec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Premultiplied pixel export converter package
// Shared types, register codes, arithmetic constants and the reciprocal table
// used by the straight-alpha divider.
// ----------------------------------------------------------------------------
package ppec_pkg;

  localparam int unsigned ChanW  = 8;   // width of one color or alpha byte
  localparam int unsigned CfgIdxW = 2;  // width of the register index
  localparam int unsigned CfgDatW = 8;  // width of the register write data
  localparam int unsigned RecipW = 17;  // reciprocal of alpha, 2^16 / a
  localparam int unsigned RecipShift = 16;

  localparam logic [ChanW-1:0] SatMax    = 8'd255;
  localparam logic [15:0]      HalfRound = 16'd127;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE        = 2'd0,
    REG_MATTE_RED   = 2'd1,
    REG_MATTE_GREEN = 2'd2,
    REG_MATTE_BLUE  = 2'd3
  } cfg_reg_e;

  // Output modes. The unused code behaves like the composite modes.
  typedef enum logic [1:0] {
    MODE_STRAIGHT   = 2'd0,
    MODE_MATTE_BGRA = 2'd1,
    MODE_MATTE_BGR  = 2'd2
  } mode_e;

  typedef logic [RecipW-1:0] recip_tbl_t [256];

  // Floor of 2^16 / a for every alpha, built by shift-subtract long division
  // during elaboration. Entry zero is unused and holds zero.
  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t  tbl;
    int unsigned rem;
    int unsigned quo;
    tbl[0] = '0;
    for (int unsigned a = 1; a < 256; a++) begin
      rem = 0;
      quo = 0;
      for (int i = RecipShift; i >= 0; i--) begin
        rem = (rem << 1) | ((32'h0001_0000 >> i) & 32'd1);
        quo = quo << 1;
        if (rem >= a) begin
          rem = rem - a;
          quo = quo | 32'd1;
        end
      end
      tbl[a] = RecipW'(quo);
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RecipTbl = build_recip_tbl();

endpackage

FILE: sv/ppec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Premultiplied pixel export converter channels
// Valid/ready channels for input pixels, converted pixels and register writes.
// ----------------------------------------------------------------------------
interface ppec_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [ppec_pkg::ChanW-1:0] in_red;
  logic [ppec_pkg::ChanW-1:0] in_green;
  logic [ppec_pkg::ChanW-1:0] in_blue;
  logic [ppec_pkg::ChanW-1:0] in_alpha;
  logic                       frame_end_in;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, frame_end_in,
                  input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, frame_end_in,
                  output ready);
endinterface

interface ppec_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [ppec_pkg::ChanW-1:0] out_blue;
  logic [ppec_pkg::ChanW-1:0] out_green;
  logic [ppec_pkg::ChanW-1:0] out_red;
  logic [ppec_pkg::ChanW-1:0] out_alpha;
  logic                       frame_end_out;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, frame_end_out,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, frame_end_out,
                  output ready);
endinterface

interface ppec_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppec_pkg::CfgIdxW-1:0] index;
  logic [ppec_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/premultiplied_pixel_export_convert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Premultiplied pixel export converter
// Turns premultiplied RGBA pixels into straight-alpha or matte-composited
// pixels in blue-green-red order, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while the output is not stalled, and
// it gives each result out in the same order as the pixels came in. It is a
// four-stage pipeline: stage one forms the scaled color and the matte share and
// looks up the reciprocal of alpha, stage two multiplies by the reciprocals,
// stage three forms the remainders, and the output register applies the
// one-step correction, the saturation and the mode select. Every stage carries
// its own valid bit and only moves forward when the stage after it is free, so
// back-pressure on the output stalls the pipe without losing or repeating an
// item, and a new item is still taken while a finished one waits as long as a
// stage is empty. Registers are written through the configuration port, which
// is always ready; they should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module premultiplied_pixel_export_convert_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppec_pix_in_if.sink           in_i,
  ppec_pix_out_if.source        out_o,
  ppec_cfg_if.sink              cfg_i
);

  localparam int unsigned NumCol = 3;  // 0 blue, 1 green, 2 red

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]                  mode_q;
  logic [ppec_pkg::ChanW-1:0]  matte_q [NumCol];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ppec_pkg::MODE_STRAIGHT;
      matte_q[0] <= '0;
      matte_q[1] <= '0;
      matte_q[2] <= '0;
    end else if (cfg_i.valid) begin
      unique case (ppec_pkg::cfg_reg_e'(cfg_i.index))
        ppec_pkg::REG_MODE:        mode_q     <= cfg_i.data[1:0];
        ppec_pkg::REG_MATTE_RED:   matte_q[2] <= cfg_i.data;
        ppec_pkg::REG_MATTE_GREEN: matte_q[1] <= cfg_i.data;
        ppec_pkg::REG_MATTE_BLUE:  matte_q[0] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it is moving on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic free1, free2, free3, free4;

  assign free4 = !v4_q || out_o.ready;
  assign free3 = !v3_q || free4;
  assign free2 = !v2_q || free3;
  assign free1 = !v1_q || free2;

  assign in_i.ready = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (free1) v1_q <= in_i.valid;
      if (free2) v2_q <= v1_q;
      if (free3) v3_q <= v2_q;
      if (free4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the straight path needs N = c*255 + a/2 and the reciprocal of a.
  // The composite path needs X = m*(255-a) + 127.
  // --------------------------------------------------------------------------
  logic [ppec_pkg::ChanW-1:0]  in_col [NumCol];
  logic [ppec_pkg::ChanW-1:0]  inv_alpha;
  logic [15:0]                 num_s1 [NumCol];
  logic [15:0]                 mat_s1 [NumCol];

  assign in_col[0] = in_i.in_blue;
  assign in_col[1] = in_i.in_green;
  assign in_col[2] = in_i.in_red;
  assign inv_alpha = ppec_pkg::SatMax - in_i.in_alpha;

  always_comb begin
    for (int k = 0; k < NumCol; k++) begin
      num_s1[k] = {in_col[k], 8'h00} - {8'h00, in_col[k]} + {9'h000, in_i.in_alpha[7:1]};
      mat_s1[k] = 16'(16'(matte_q[k]) * 16'(inv_alpha)) + ppec_pkg::HalfRound;
    end
  end

  logic [ppec_pkg::ChanW-1:0]  col1_q [NumCol];
  logic [15:0]                 num1_q [NumCol];
  logic [15:0]                 mat1_q [NumCol];
  logic [ppec_pkg::ChanW-1:0]  alpha1_q;
  logic [ppec_pkg::RecipW-1:0] recip1_q;
  logic                        straight1_q;
  logic                        fe1_q;

  always_ff @(posedge clk_i) begin
    if (free1 && in_i.valid) begin
      col1_q      <= in_col;
      num1_q      <= num_s1;
      mat1_q      <= mat_s1;
      alpha1_q    <= in_i.in_alpha;
      recip1_q    <= ppec_pkg::RecipTbl[in_i.in_alpha];
      straight1_q <= (mode_q == ppec_pkg::MODE_STRAIGHT);
      fe1_q       <= in_i.frame_end_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quotient estimates, each at most one below the true quotient.
  // N / a is taken as (N * floor(2^16/a)) >> 16 and X / 255 as (X * 257) >> 16.
  // --------------------------------------------------------------------------
  logic [32:0] num_prod [NumCol];
  logic [24:0] mat_prod [NumCol];

  always_comb begin
    for (int k = 0; k < NumCol; k++) begin
      num_prod[k] = 33'(num1_q[k]) * 33'(recip1_q);
      mat_prod[k] = 25'(mat1_q[k]) * 25'd257;
    end
  end

  logic [ppec_pkg::ChanW-1:0]  col2_q [NumCol];
  logic [15:0]                 num2_q [NumCol];
  logic [15:0]                 mat2_q [NumCol];
  logic [15:0]                 nq2_q  [NumCol];
  logic [ppec_pkg::ChanW-1:0]  mq2_q  [NumCol];
  logic [ppec_pkg::ChanW-1:0]  alpha2_q;
  logic                        straight2_q;
  logic                        fe2_q;

  always_ff @(posedge clk_i) begin
    if (free2 && v1_q) begin
      col2_q      <= col1_q;
      num2_q      <= num1_q;
      mat2_q      <= mat1_q;
      for (int k = 0; k < NumCol; k++) begin
        nq2_q[k] <= num_prod[k][31:16];
        mq2_q[k] <= mat_prod[k][23:16];
      end
      alpha2_q    <= alpha1_q;
      straight2_q <= straight1_q;
      fe2_q       <= fe1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: remainders of the estimates. Both stay below twice the divisor.
  // --------------------------------------------------------------------------
  logic [23:0] num_rem [NumCol];
  logic [15:0] mat_rem [NumCol];

  always_comb begin
    for (int k = 0; k < NumCol; k++) begin
      num_rem[k] = 24'(num2_q[k]) - 24'(24'(nq2_q[k]) * 24'(alpha2_q));
      mat_rem[k] = mat2_q[k] - 16'(16'(mq2_q[k]) * 16'd255);
    end
  end

  logic [ppec_pkg::ChanW-1:0]  col3_q [NumCol];
  logic [15:0]                 nq3_q  [NumCol];
  logic [ppec_pkg::ChanW-1:0]  mq3_q  [NumCol];
  logic [8:0]                  nr3_q  [NumCol];
  logic [8:0]                  mr3_q  [NumCol];
  logic [ppec_pkg::ChanW-1:0]  alpha3_q;
  logic                        straight3_q;
  logic                        fe3_q;

  always_ff @(posedge clk_i) begin
    if (free3 && v2_q) begin
      col3_q      <= col2_q;
      nq3_q       <= nq2_q;
      mq3_q       <= mq2_q;
      for (int k = 0; k < NumCol; k++) begin
        nr3_q[k] <= num_rem[k][8:0];
        mr3_q[k] <= mat_rem[k][8:0];
      end
      alpha3_q    <= alpha2_q;
      straight3_q <= straight2_q;
      fe3_q       <= fe2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: correct each estimate by one where the remainder reached the
  // divisor, saturate, and pick the result of the active mode. Zero alpha in
  // straight mode gives zero colors.
  // --------------------------------------------------------------------------
  logic [16:0]                num_quo [NumCol];
  logic [8:0]                 mat_quo [NumCol];
  logic [9:0]                 mat_sum [NumCol];
  logic [ppec_pkg::ChanW-1:0] res_col [NumCol];
  logic [ppec_pkg::ChanW-1:0] res_alpha;

  always_comb begin
    for (int k = 0; k < NumCol; k++) begin
      num_quo[k] = 17'(nq3_q[k]) + 17'(nr3_q[k] >= {1'b0, alpha3_q});
      mat_quo[k] = 9'(mq3_q[k]) + 9'(mr3_q[k] >= 9'd255);
      mat_sum[k] = 10'(col3_q[k]) + 10'(mat_quo[k]);
      if (straight3_q) begin
        if (alpha3_q == '0) begin
          res_col[k] = '0;
        end else if (num_quo[k] > 17'(ppec_pkg::SatMax)) begin
          res_col[k] = ppec_pkg::SatMax;
        end else begin
          res_col[k] = num_quo[k][7:0];
        end
      end else if (mat_sum[k] > 10'(ppec_pkg::SatMax)) begin
        res_col[k] = ppec_pkg::SatMax;
      end else begin
        res_col[k] = mat_sum[k][7:0];
      end
    end
    res_alpha = straight3_q ? alpha3_q : ppec_pkg::SatMax;
  end

  logic [ppec_pkg::ChanW-1:0] out_col_q [NumCol];
  logic [ppec_pkg::ChanW-1:0] out_alpha_q;
  logic                       out_fe_q;

  always_ff @(posedge clk_i) begin
    if (free4 && v3_q) begin
      out_col_q   <= res_col;
      out_alpha_q <= res_alpha;
      out_fe_q    <= fe3_q;
    end
  end

  assign out_o.valid         = v4_q;
  assign out_o.out_blue      = out_col_q[0];
  assign out_o.out_green     = out_col_q[1];
  assign out_o.out_red       = out_col_q[2];
  assign out_o.out_alpha     = out_alpha_q;
  assign out_o.frame_end_out = out_fe_q;

endmodule
